@@ sv/clrle_pkg.sv @@
// Package for the code-length RLE unpacker: widths, symbol codes, state and
// record types, and the one-symbol decode step.
// No dependencies.
package clrle_pkg;

  localparam int unsigned TABLE_ENTRIES = 273;
  localparam int unsigned SYMBOL_BITS   = 5;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned CNT_W         = 10;
  localparam int unsigned BYTE_CNT_W    = 10;
  localparam int unsigned BUF_W         = 12;
  localparam int unsigned BITS_W        = 4;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0]      TABLE_END = CNT_W'(TABLE_ENTRIES);
  localparam logic [BYTE_CNT_W-1:0] BYTE_SAT  = '1;

  localparam logic [SYMBOL_BITS-1:0] SYM_ZERO_RUN = 5'd30;
  localparam logic [SYMBOL_BITS-1:0] SYM_LONG_RUN = 5'd31;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_ADD  = 2'd1,
    ESC_HIGH = 2'd2
  } clrle_esc_e;

  typedef struct packed {
    logic [BUF_W-1:0]      bit_buf;
    logic [BITS_W-1:0]     bit_cnt;
    clrle_esc_e            esc;
    logic [CNT_W-1:0]      run_acc;
    logic [IDX_W-1:0]      idx;
    logic                  full;
    logic [BYTE_CNT_W-1:0] bytes;
  } clrle_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]       start_index;
    logic [SYMBOL_BITS-1:0] length_value;
    logic [CNT_W-1:0]       run_count;
    logic                   table_done;
    logic [BYTE_CNT_W-1:0]  bytes_used;
    logic                   last_of_item;
  } clrle_rec_t;

  typedef struct packed {
    logic       valid;
    clrle_rec_t rec;
  } clrle_slot_t;

  typedef struct packed {
    clrle_state_t st;
    clrle_slot_t  slot;
  } clrle_step_t;

  // Consume one symbol from the bit buffer; caller guarantees bit_cnt >= 5.
  function automatic clrle_step_t clrle_sym_step(clrle_state_t s);
    clrle_step_t            r;
    logic [BITS_W-1:0]      c;
    logic [SYMBOL_BITS-1:0] sym;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       remain;
    logic [CNT_W-1:0]       sum;
    r      = '0;
    r.st   = s;
    c      = s.bit_cnt - BITS_W'(SYMBOL_BITS);
    sym    = SYMBOL_BITS'(s.bit_buf >> c);
    cnt    = '0;
    remain = '0;
    sum    = '0;
    r.st.bit_cnt = c;
    r.st.bit_buf = s.bit_buf & ((BUF_W'(1) << c) - BUF_W'(1));
    if (sym == SYM_ZERO_RUN) begin
      r.st.esc = ESC_ADD;
    end else if (sym == SYM_LONG_RUN) begin
      r.st.esc = ESC_HIGH;
    end else begin
      unique case (s.esc)
        ESC_NONE: begin
          sum                     = {1'b0, s.idx} + CNT_W'(1);
          r.st.idx                = IDX_W'(sum);
          r.st.full               = (sum >= TABLE_END);
          r.slot.valid            = 1'b1;
          r.slot.rec.start_index  = s.idx;
          r.slot.rec.length_value = sym;
          r.slot.rec.run_count    = CNT_W'(1);
          r.slot.rec.table_done   = (sum >= TABLE_END);
        end
        ESC_ADD: begin
          cnt          = s.run_acc + {{(CNT_W-SYMBOL_BITS){1'b0}}, sym};
          remain       = TABLE_END - {1'b0, s.idx};
          r.st.esc     = ESC_NONE;
          r.st.run_acc = '0;
          if (cnt != '0) begin
            if (cnt > remain) cnt = remain;
            sum                     = {1'b0, s.idx} + cnt;
            r.st.idx                = IDX_W'(sum);
            r.st.full               = (sum >= TABLE_END);
            r.slot.valid            = 1'b1;
            r.slot.rec.start_index  = s.idx;
            r.slot.rec.length_value = '0;
            r.slot.rec.run_count    = cnt;
            r.slot.rec.table_done   = (sum >= TABLE_END);
          end
        end
        default: begin
          r.st.run_acc = {sym, {(CNT_W-SYMBOL_BITS){1'b0}}};
          r.st.esc     = ESC_ADD;
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ sv/clrle_if.sv @@
// Request channels of the code-length RLE unpacker: header bytes in,
// run records out. Depends on clrle_pkg.
interface clrle_in_if;
  import clrle_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface clrle_out_if;
  import clrle_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IDX_W-1:0]       start_index;
  logic [SYMBOL_BITS-1:0] length_value;
  logic [CNT_W-1:0]       run_count;
  logic                   table_done;
  logic [BYTE_CNT_W-1:0]  bytes_used;
  logic                   last_of_item;

  modport source (output valid, output start_index, output length_value,
                  output run_count, output table_done, output bytes_used,
                  output last_of_item, input ready);
  modport sink   (input valid, input start_index, input length_value,
                  input run_count, input table_done, input bytes_used,
                  input last_of_item, output ready);
endinterface

@@ sv/clrle_decode.sv @@
// Byte decoder: appends one byte to the bit buffer, decodes up to two
// symbols and returns the next state and up to two records. Uses clrle_pkg.
module clrle_decode (
  input  clrle_pkg::clrle_state_t state_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    restart_i,
  output clrle_pkg::clrle_state_t state_o,
  output clrle_pkg::clrle_slot_t  slot0_o,
  output clrle_pkg::clrle_slot_t  slot1_o
);
  import clrle_pkg::*;

  clrle_state_t s0, s1;
  clrle_step_t  step_a, step_b;
  clrle_state_t fin;

  always_comb begin
    s0 = restart_i ? '0 : state_i;

    s1         = s0;
    s1.bit_buf = {s0.bit_buf[BUF_W-9:0], data_byte_i};
    s1.bit_cnt = s0.bit_cnt + BITS_W'(8);
    if (s0.bytes != BYTE_SAT) s1.bytes = s0.bytes + BYTE_CNT_W'(1);

    // At least eight bits are present, so the first symbol always decodes.
    step_a = clrle_sym_step(s1);
    if (step_a.st.bit_cnt >= BITS_W'(SYMBOL_BITS) && !step_a.st.full) begin
      step_b = clrle_sym_step(step_a.st);
    end else begin
      step_b      = '0;
      step_b.st   = step_a.st;
    end

    fin = step_b.st;
    if (fin.full) begin
      fin.bit_buf = '0;
      fin.bit_cnt = '0;
    end

    slot0_o = step_a.slot.valid ? step_a.slot : step_b.slot;
    slot1_o = step_a.slot.valid ? step_b.slot : '0;
    slot0_o.rec.bytes_used   = s1.bytes;
    slot1_o.rec.bytes_used   = s1.bytes;
    slot0_o.rec.last_of_item = !slot1_o.valid;
    slot1_o.rec.last_of_item = 1'b1;

    // A full table swallows the byte: nothing changes, nothing is emitted.
    if (s0.full) begin
      state_o = s0;
      slot0_o = '0;
      slot1_o = '0;
    end else begin
      state_o = fin;
    end
  end

endmodule

@@ sv/code_length_rle_unpacker.sv @@
// Code-length RLE unpacker: header bytes in, start/value/count records out.
// A byte taken into the input register stage is decoded there, and its records
// are written into the record queue, whose head drives the output.
// Throughput: one byte per cycle while the queue has room for two records; a
// byte that yields two records outpaces the single output port and can stall input.
// Reset (rst_ni low, asynchronous) clears decode state and the record queue.
module code_length_rle_unpacker (
  input  logic               clk_i,
  input  logic               rst_ni,
  clrle_in_if.sink           req_i,
  clrle_out_if.source        rec_o
);
  import clrle_pkg::*;

  // Input register stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_restart_q;
  logic       s1_fire;

  // Decoder state carried between bytes.
  clrle_state_t state_q, state_d;
  clrle_slot_t  slot0, slot1;

  // Record queue, filled up to two per cycle, drained one per cycle.
  clrle_rec_t        queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_after_pop;
  logic              pop;
  logic              room;
  logic [1:0]        n_push;

  clrle_decode u_decode (
    .state_i     (state_q),
    .data_byte_i (s1_byte_q),
    .restart_i   (s1_restart_q),
    .state_o     (state_d),
    .slot0_o     (slot0),
    .slot1_o     (slot1)
  );

  assign pop           = (cnt_q != '0) && rec_o.ready;
  assign cnt_after_pop = cnt_q - QCNT_W'(pop);
  // Room for the worst case of two new records.
  assign room          = (cnt_after_pop <= QCNT_W'(QUEUE_DEPTH - 2));
  assign s1_fire       = s1_valid_q && room;
  assign req_i.ready   = !s1_valid_q || s1_fire;
  assign n_push        = s1_fire ? (2'(slot0.valid) + 2'(slot1.valid)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_byte_q    <= req_i.data_byte;
      s1_restart_q <= req_i.restart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
      cnt_q    <= cnt_after_pop + QCNT_W'(n_push);
    end
  end

  // slot1 is only valid when slot0 is, so records pack from wr_ptr_q.
  always_ff @(posedge clk_i) begin
    if (s1_fire && slot0.valid) queue_q[wr_ptr_q] <= slot0.rec;
    if (s1_fire && slot1.valid) queue_q[wr_ptr_q + QPTR_W'(1)] <= slot1.rec;
  end

  assign rec_o.valid        = (cnt_q != '0);
  assign rec_o.start_index  = queue_q[rd_ptr_q].start_index;
  assign rec_o.length_value = queue_q[rd_ptr_q].length_value;
  assign rec_o.run_count    = queue_q[rd_ptr_q].run_count;
  assign rec_o.table_done   = queue_q[rd_ptr_q].table_done;
  assign rec_o.bytes_used   = queue_q[rd_ptr_q].bytes_used;
  assign rec_o.last_of_item = queue_q[rd_ptr_q].last_of_item;

endmodule
